// ----- rtl/fsep_pkg.sv -----
// ----------------------------------------------------------------------------
// fsep_pkg: shared types and constants of the flock separation block
// Holds the table size, field widths, register indexes, the token and control
// structs that travel along the cell chain, and the output saturation helper.
// ----------------------------------------------------------------------------
package fsep_pkg;

	// Table and position sizes.
	localparam int MAX_AGENTS = 64;
	localparam int POS_WIDTH  = 16;

	// Fixed field widths.
	localparam int IDX_W   = 6;
	localparam int CNT_CFG_W = 7;
	localparam int RANGE_W = 16;
	localparam int OUT_W   = 23;
	localparam int CFG_DATA_W = 16;

	// Derived widths.
	localparam int AW      = (MAX_AGENTS > 1) ? $clog2(MAX_AGENTS) : 1;
	localparam int CNT_W   = ($clog2(MAX_AGENTS + 1) > CNT_CFG_W) ?
	                         $clog2(MAX_AGENTS + 1) : CNT_CFG_W;
	localparam int DIFF_W  = POS_WIDTH + 1;
	localparam int CMP_W   = (DIFF_W > RANGE_W) ? DIFF_W : RANGE_W;
	localparam int SUM_W   = POS_WIDTH + 1 + AW;
	localparam int EXT_W   = (SUM_W > OUT_W) ? SUM_W : OUT_W + 1;

	// Operation codes.
	localparam logic OP_STORE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// Configuration register indexes.
	localparam logic REG_BOID_COUNT = 1'b0;
	localparam logic REG_PROT_RANGE = 1'b1;

	// Reset values of the registers.
	localparam logic [CNT_CFG_W-1:0] BOID_COUNT_RST = CNT_CFG_W'(64);
	localparam logic [RANGE_W-1:0]   PROT_RANGE_RST = RANGE_W'(128);

	// Query token handed from cell to cell.
	typedef struct packed {
		logic                    vld;
		logic signed [SUM_W-1:0] sx;
		logic signed [SUM_W-1:0] sy;
	} fsep_tok_t;

	// Values seen by every cell at once.
	typedef struct packed {
		logic [POS_WIDTH-1:0] qx;
		logic [POS_WIDTH-1:0] qy;
		logic [RANGE_W-1:0]   range;
		logic [CNT_W-1:0]     count;
		logic [CNT_W-1:0]     qidx;
		logic                 wr_en;
		logic [CNT_W-1:0]     wr_idx;
		logic [POS_WIDTH-1:0] wr_x;
		logic [POS_WIDTH-1:0] wr_y;
	} fsep_ctl_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_RUN,
		ST_FINISH
	} fsep_state_t;

	// Clip an accumulated sum to the signed output range.
	function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [SUM_W-1:0] v);
		logic signed [EXT_W-1:0] e;
		logic signed [EXT_W-1:0] hi;
		logic signed [EXT_W-1:0] lo;
		logic signed [OUT_W-1:0] r;
		e  = EXT_W'(v);
		hi = EXT_W'({1'b0, {(OUT_W-1){1'b1}}});
		lo = -hi - EXT_W'(1);
		if (e > hi) begin
			r = {1'b0, {(OUT_W-1){1'b1}}};
		end else if (e < lo) begin
			r = {1'b1, {(OUT_W-1){1'b0}}};
		end else begin
			r = e[OUT_W-1:0];
		end
		return r;
	endfunction

endpackage

// ----- rtl/fsep_cell.sv -----
// ----------------------------------------------------------------------------
// fsep_cell: one agent entry of the separation chain
// Holds one stored position. When the query token passes, the cell adds its
// separation term to the running sums and hands the token to its neighbor.
// ----------------------------------------------------------------------------
module fsep_cell
	import fsep_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic [CNT_W-1:0] cell_id,
	input  fsep_ctl_t        ctl,
	input  fsep_tok_t        tok_in,
	output fsep_tok_t        tok_out
);

	logic [POS_WIDTH-1:0]    px_q;
	logic [POS_WIDTH-1:0]    py_q;
	logic signed [DIFF_W-1:0] dx;
	logic signed [DIFF_W-1:0] dy;
	logic [DIFF_W-1:0]       ax;
	logic [DIFF_W-1:0]       ay;
	logic                    hit;
	logic                    vld_s1;
	logic signed [SUM_W-1:0] sx_s1;
	logic signed [SUM_W-1:0] sy_s1;

	// Store the position addressed to this entry.
	always_ff @(posedge clk) begin
		if (ctl.wr_en && (ctl.wr_idx == cell_id)) begin
			px_q <= ctl.wr_x;
			py_q <= ctl.wr_y;
		end
	end

	// Differences to the query agent and the closeness test.
	always_comb begin
		dx  = $signed({1'b0, ctl.qx}) - $signed({1'b0, px_q});
		dy  = $signed({1'b0, ctl.qy}) - $signed({1'b0, py_q});
		ax  = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
		ay  = dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
		hit = (cell_id < ctl.count) && (cell_id != ctl.qidx) &&
		      (CMP_W'(ax) < CMP_W'(ctl.range)) && (CMP_W'(ay) < CMP_W'(ctl.range));
	end

	// Token stage: only the valid bit needs a reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= tok_in.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (hit) begin
			sx_s1 <= tok_in.sx + SUM_W'(dx);
			sy_s1 <= tok_in.sy + SUM_W'(dy);
		end else begin
			sx_s1 <= tok_in.sx;
			sy_s1 <= tok_in.sy;
		end
	end

	assign tok_out.vld = vld_s1;
	assign tok_out.sx  = sx_s1;
	assign tok_out.sy  = sy_s1;

endmodule

// ----- rtl/fsep_chain.sv -----
// ----------------------------------------------------------------------------
// fsep_chain: row of agent cells
// Connects one cell per table entry in a line; the query token enters at the
// first cell and leaves the last one after passing each cell's token register.
// ----------------------------------------------------------------------------
module fsep_chain
	import fsep_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  fsep_ctl_t ctl,
	input  fsep_tok_t tok_in,
	output fsep_tok_t tok_out
);

	fsep_tok_t tok [MAX_AGENTS+1];
	logic [MAX_AGENTS-1:0] vld_vec;

	assign tok[0] = tok_in;

	// One cell per entry, each passing the token to the next.
	for (genvar k = 0; k < MAX_AGENTS; k++) begin : g_cell
		fsep_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.cell_id (CNT_W'(k)),
			.ctl     (ctl),
			.tok_in  (tok[k]),
			.tok_out (tok[k+1])
		);
		assign vld_vec[k] = tok[k+1].vld;
	end

	assign tok_out = tok[MAX_AGENTS];

	// Only one query is ever in flight along the row.
	a_single_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(vld_vec))
		else $error("more than one query token in the cell chain");

	// A token entering the row is not followed directly by another.
	a_no_inject_behind: assert property (@(posedge clk) disable iff (!arst_n)
		tok_in.vld |=> !tok_in.vld)
		else $error("token injected on consecutive cycles");

	// A token leaving the row was injected exactly one pass earlier.
	a_pass_length: assert property (@(posedge clk) disable iff (!arst_n)
		tok_out.vld |-> $past(tok_in.vld, MAX_AGENTS))
		else $error("token left the chain after an unexpected delay");

endmodule

// ----- rtl/flock_separation_sum.sv -----
// ----------------------------------------------------------------------------
// flock_separation_sum: separation vector of a flock agent
// Keeps a table of agent positions and, per query, sums the position
// differences to every close neighbor by passing a token along a row of cells.
// ----------------------------------------------------------------------------
//
//  Channel  Handshake           Payload
//  -------  ------------------  ----------------------------------
//  in       in_valid/in_stall   op, agent_index, pos_x, pos_y
//  out      out_valid/out_stall agent_id, sep_dx, sep_dy
//  cfg      cfg_valid/cfg_ready cfg_index, cfg_data
//
//  A store transaction is accepted while idle and the next item may follow at once.
//  A query stalls the input until the sequencer is idle again: the accept, one read
//  of the query position from the position memory, the pass through every cell of
//  the chain and one capture. Its result is then loaded into the output register
//  once that register is free.
//  Reset restores boid_count to 64 and the protection range to 128; the table
//  itself holds no defined values until written.
//  A stalled result waits in the output register while the next item is taken;
//  a second finished query waits until that register frees.
// ----------------------------------------------------------------------------
module flock_separation_sum
	import fsep_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	// Input channel
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic                    op,
	input  logic [IDX_W-1:0]        agent_index,
	input  logic [POS_WIDTH-1:0]    pos_x,
	input  logic [POS_WIDTH-1:0]    pos_y,
	// Output channel
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [IDX_W-1:0]        agent_id,
	output logic signed [OUT_W-1:0] sep_dx,
	output logic signed [OUT_W-1:0] sep_dy,
	// Configuration channel
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic                    cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data
);

	fsep_state_t state_q, state_d;

	logic [CNT_CFG_W-1:0]    boid_count_q;
	logic [RANGE_W-1:0]      prot_range_q;
	logic [POS_WIDTH-1:0]    mem_x [MAX_AGENTS];
	logic [POS_WIDTH-1:0]    mem_y [MAX_AGENTS];
	logic [POS_WIDTH-1:0]    qx_q;
	logic [POS_WIDTH-1:0]    qy_q;
	logic [IDX_W-1:0]        idx_q;
	logic                    idx_ok_q;
	logic signed [OUT_W-1:0] res_dx_q;
	logic signed [OUT_W-1:0] res_dy_q;
	logic                    out_valid_q;
	logic [IDX_W-1:0]        out_id_q;
	logic signed [OUT_W-1:0] out_dx_q;
	logic signed [OUT_W-1:0] out_dy_q;

	logic                    in_accept;
	logic                    idx_ok;
	logic [AW-1:0]           addr;
	logic [CNT_W-1:0]        idx_ext;
	logic [CNT_W-1:0]        count_ext;
	logic                    out_free;
	logic                    out_load;
	logic                    inject;
	fsep_ctl_t               ctl;
	fsep_tok_t               tok_in;
	fsep_tok_t               tok_out;

	assign in_accept = in_valid && !in_stall;
	assign idx_ext   = CNT_W'(agent_index);
	assign idx_ok    = idx_ext < CNT_W'(MAX_AGENTS);
	assign addr      = AW'(agent_index);
	assign count_ext = CNT_W'(boid_count_q);
	assign out_free  = !out_valid_q || !out_stall;
	assign cfg_ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			boid_count_q <= BOID_COUNT_RST;
			prot_range_q <= PROT_RANGE_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_BOID_COUNT: boid_count_q <= cfg_data[CNT_CFG_W-1:0];
				REG_PROT_RANGE: prot_range_q <= cfg_data[RANGE_W-1:0];
				default: ;
			endcase
		end
	end

	// Copy of the table for reading the query position.
	always_ff @(posedge clk) begin
		if (in_accept && (op == OP_STORE) && idx_ok) begin
			mem_x[addr] <= pos_x;
			mem_y[addr] <= pos_y;
		end
		if (in_accept && (op == OP_QUERY)) begin
			qx_q <= mem_x[addr];
			qy_q <= mem_y[addr];
		end
	end

	// Query context held for the whole pass.
	always_ff @(posedge clk) begin
		if (in_accept && (op == OP_QUERY)) begin
			idx_q    <= agent_index;
			idx_ok_q <= idx_ok;
		end
	end

	// Broadcast values for the cell row.
	always_comb begin
		ctl.qx     = qx_q;
		ctl.qy     = qy_q;
		ctl.range  = prot_range_q;
		ctl.count  = (count_ext > CNT_W'(MAX_AGENTS)) ? CNT_W'(MAX_AGENTS) : count_ext;
		ctl.qidx   = CNT_W'(idx_q);
		ctl.wr_en  = in_accept && (op == OP_STORE) && idx_ok;
		ctl.wr_idx = idx_ext;
		ctl.wr_x   = pos_x;
		ctl.wr_y   = pos_y;
		tok_in.vld = inject;
		tok_in.sx  = '0;
		tok_in.sy  = '0;
	end

	fsep_chain u_chain (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.tok_in  (tok_in),
		.tok_out (tok_out)
	);

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and sequencer outputs.
	always_comb begin
		state_d  = state_q;
		in_stall = 1'b1;
		inject   = 1'b0;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid && (op == OP_QUERY)) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				inject  = 1'b1;
				state_d = ST_RUN;
			end
			ST_RUN: begin
				if (tok_out.vld) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Capture and clip the sums as the token leaves the row.
	always_ff @(posedge clk) begin
		if ((state_q == ST_RUN) && tok_out.vld) begin
			res_dx_q <= idx_ok_q ? sat_out(tok_out.sx) : '0;
			res_dy_q <= idx_ok_q ? sat_out(tok_out.sy) : '0;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_id_q <= idx_q;
			out_dx_q <= res_dx_q;
			out_dy_q <= res_dy_q;
		end
	end

	assign out_valid = out_valid_q;
	assign agent_id  = out_id_q;
	assign sep_dx    = out_dx_q;
	assign sep_dy    = out_dy_q;

	// A result appears only after the finish state.
	a_out_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_FINISH))
		else $error("result presented without a finished query");

	// The token leaves the row only while the sequencer waits for it.
	a_tail_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		tok_out.vld |-> (state_q == ST_RUN))
		else $error("query token left the chain outside the run state");

	// A new result carries the index of the query that produced it.
	a_result_id: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> (agent_id == $past(idx_q)))
		else $error("result index differs from the queried agent");

endmodule

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench of flock_separation_sum
// Loads agent positions and asks for separation vectors through the
// valid/stall channels, and writes both registers between phases. A
// scoreboard keeps its own copy of the position table and the registers and
// computes each expected vector, which is compared field by field with what
// the block returns. Sender gaps and receiver stalls change from phase to
// phase, and one long output hold lets the block fill up.
// ----------------------------------------------------------------------------
module tb_top
	import fsep_pkg::*;
();

	localparam int HOLD_CYCLES = 400;

	// One expected separation result.
	typedef struct {
		logic [IDX_W-1:0]        id;
		logic signed [OUT_W-1:0] dx;
		logic signed [OUT_W-1:0] dy;
	} sep_vector_t;

	// Scoreboard: mirrors the position table and registers of the block.
	class separation_tracker;
		logic [POS_WIDTH-1:0] x_copy[MAX_AGENTS];
		logic [POS_WIDTH-1:0] y_copy[MAX_AGENTS];
		logic [CNT_CFG_W-1:0] agent_count = BOID_COUNT_RST;
		logic [RANGE_W-1:0]   near_limit  = PROT_RANGE_RST;
		sep_vector_t          expected_vectors[$];
		int                   error_count     = 0;
		int                   items_taken     = 0;
		int                   vectors_checked = 0;

		function void set_register(logic idx, logic [CFG_DATA_W-1:0] data);
			if (idx == REG_BOID_COUNT) begin
				agent_count = data[CNT_CFG_W-1:0];
			end else begin
				near_limit = data[RANGE_W-1:0];
			end
		endfunction

		// Clip a sum to the signed output width.
		function logic signed [OUT_W-1:0] clip(longint v);
			longint top;
			top = (longint'(1) <<< (OUT_W - 1)) - 1;
			if (v > top) begin
				v = top;
			end else if (v < -top - 1) begin
				v = -top - 1;
			end
			return v[OUT_W-1:0];
		endfunction

		// Note an accepted input transaction and predict its result.
		function void take_item(logic kind, logic [IDX_W-1:0] idx,
		                        logic [POS_WIDTH-1:0] px, logic [POS_WIDTH-1:0] py);
			longint      sum_x;
			longint      sum_y;
			longint      diff_x;
			longint      diff_y;
			int          limit;
			sep_vector_t v;
			items_taken++;
			if (kind == OP_STORE) begin
				x_copy[idx] = px;
				y_copy[idx] = py;
				return;
			end
			limit = (agent_count > MAX_AGENTS) ? MAX_AGENTS : agent_count;
			sum_x = 0;
			sum_y = 0;
			for (int k = 0; k < limit; k++) begin
				if (k == idx) continue;
				diff_x = longint'(x_copy[idx]) - longint'(x_copy[k]);
				diff_y = longint'(y_copy[idx]) - longint'(y_copy[k]);
				if ((diff_x < 0 ? -diff_x : diff_x) < longint'(near_limit) &&
				    (diff_y < 0 ? -diff_y : diff_y) < longint'(near_limit)) begin
					sum_x += diff_x;
					sum_y += diff_y;
				end
			end
			v.id = idx;
			v.dx = clip(sum_x);
			v.dy = clip(sum_y);
			expected_vectors.insert(expected_vectors.size(), v);
		endfunction

		// Compare one returned result with the oldest expectation.
		function void check_vector(logic [IDX_W-1:0] id, logic signed [OUT_W-1:0] dx,
		                           logic signed [OUT_W-1:0] dy);
			sep_vector_t v;
			if (expected_vectors.size() == 0) begin
				$display("%0t: unexpected result: agent_id %0d sep_dx %0d sep_dy %0d",
				         $time, id, dx, dy);
				error_count++;
				return;
			end
			v = expected_vectors.pop_front();
			vectors_checked++;
			if (id !== v.id) begin
				$display("%0t: agent_id mismatch: expected %0d, actual %0d", $time, v.id, id);
				error_count++;
			end
			if (dx !== v.dx) begin
				$display("%0t: sep_dx mismatch (agent %0d): expected %0d, actual %0d",
				         $time, v.id, v.dx, dx);
				error_count++;
			end
			if (dy !== v.dy) begin
				$display("%0t: sep_dy mismatch (agent %0d): expected %0d, actual %0d",
				         $time, v.id, v.dy, dy);
				error_count++;
			end
		endfunction

		function int pending_count();
			return expected_vectors.size();
		endfunction
	endclass

	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    in_valid;
	logic                    in_stall;
	logic                    op;
	logic [IDX_W-1:0]        agent_index;
	logic [POS_WIDTH-1:0]    pos_x;
	logic [POS_WIDTH-1:0]    pos_y;
	logic                    out_valid;
	logic                    out_stall;
	logic [IDX_W-1:0]        agent_id;
	logic signed [OUT_W-1:0] sep_dx;
	logic signed [OUT_W-1:0] sep_dy;
	logic                    cfg_valid;
	logic                    cfg_ready;
	logic                    cfg_index;
	logic [CFG_DATA_W-1:0]   cfg_data;

	separation_tracker tracker = new();

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int holds_asked    = 0;
	int holds_granted  = 0;
	int hold_left      = 0;

	flock_separation_sum dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.op          (op),
		.agent_index (agent_index),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.agent_id    (agent_id),
		.sep_dx      (sep_dx),
		.sep_dy      (sep_dy),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	// Clock generation.
	always #10 clk = ~clk;

	// Offer one input transaction, with a random gap first, and wait until it is taken.
	task automatic send_item(input logic kind, input logic [IDX_W-1:0] idx,
	                         input logic [POS_WIDTH-1:0] px, input logic [POS_WIDTH-1:0] py);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid    <= 1'b1;
		op          <= kind;
		agent_index <= idx;
		pos_x       <= px;
		pos_y       <= py;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		tracker.take_item(kind, idx, px, py);
	endtask

	// Write one register and update the scoreboard copy on acceptance.
	task automatic write_register(input logic idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		tracker.set_register(idx, data);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Stop offering input until every expected result is back, then let stores settle.
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (tracker.pending_count() > 0) @(posedge clk);
		repeat (MAX_AGENTS + 8) @(posedge clk);
	endtask

	// Pick a coordinate: mostly near a cluster center, sometimes anywhere or at an edge.
	function automatic logic [POS_WIDTH-1:0] pick_coord(input int center);
		int mode;
		int v;
		mode = $urandom_range(9);
		if (mode == 0) return POS_WIDTH'($urandom);
		if (mode == 1) return $urandom_range(1) ? {POS_WIDTH{1'b1}} : '0;
		v = center + int'($urandom_range(800)) - 400;
		if (v < 0) v = 0;
		if (v > 65535) v = 65535;
		return POS_WIDTH'(v);
	endfunction

	// One phase: new registers, new idle mix, then random stores and queries.
	// Special action at mid-phase: 1 holds the output off, 2 drains the block.
	task automatic run_phase(input int cnt, input int lim, input int s_pct, input int r_pct,
	                         input int items, input int mid_action);
		int cx;
		int cy;
		wait_drained();
		write_register(REG_BOID_COUNT, {9'($urandom_range(511)), 7'(cnt)});
		write_register(REG_PROT_RANGE, 16'(lim));
		send_idle_pct  <= s_pct;
		recv_stall_pct <= r_pct;
		cx = $urandom_range(63000, 2000);
		cy = $urandom_range(63000, 2000);
		for (int n = 0; n < items; n++) begin
			if (n == items / 2 && mid_action == 1) begin
				// Receiver holds off while queries keep coming, so the block backs up.
				holds_asked <= holds_asked + 1;
				for (int q = 0; q < 24; q++) begin
					send_item(OP_QUERY, IDX_W'($urandom), POS_WIDTH'($urandom),
					          POS_WIDTH'($urandom));
				end
			end
			if (n == items / 2 && mid_action == 2) begin
				wait_drained();
			end
			if ($urandom_range(1)) begin
				send_item(OP_QUERY, IDX_W'($urandom), POS_WIDTH'($urandom),
				          POS_WIDTH'($urandom));
			end else begin
				send_item(OP_STORE, IDX_W'($urandom), pick_coord(cx), pick_coord(cy));
			end
		end
	endtask

	// Result side: checks every accepted result and drives random or long stalls.
	initial begin : result_sink
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				tracker.check_vector(agent_id, sep_dx, sep_dy);
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (holds_granted != holds_asked) begin
				holds_granted++;
				hold_left = HOLD_CYCLES;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < recv_stall_pct);
			end
		end
	end

	// Main sequence: reset, directed cases, table fill, random phases, final verdict.
	initial begin : stimulus
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		op          = OP_STORE;
		agent_index = '0;
		pos_x       = '0;
		pos_y       = '0;
		cfg_valid   = 1'b0;
		cfg_index   = REG_BOID_COUNT;
		cfg_data    = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: four agents at the corners and inside, widest range.
		write_register(REG_BOID_COUNT, {9'h1FF, 7'd4});
		write_register(REG_PROT_RANGE, 16'hFFFF);
		send_item(OP_STORE, 6'd0, 16'h0000, 16'h0000);
		send_item(OP_STORE, 6'd1, 16'hFFFF, 16'hFFFF);
		send_item(OP_STORE, 6'd2, 16'd100, 16'd200);
		send_item(OP_STORE, 6'd3, 16'hFFFF, 16'h0000);
		send_item(OP_QUERY, 6'd0, 16'hFFFF, 16'hFFFF);
		send_item(OP_QUERY, 6'd1, 16'h5A5A, 16'hA5A5);
		send_item(OP_QUERY, 6'd2, 16'h0000, 16'h0000);
		send_item(OP_QUERY, 6'd3, 16'h1234, 16'h8765);
		// An agent past the count still sums over the first entries.
		send_item(OP_STORE, 6'd63, 16'd50, 16'd60);
		send_item(OP_QUERY, 6'd63, 16'hFFFF, 16'h0000);
		// Differences of exactly the full range do not count.
		send_item(OP_STORE, 6'd2, 16'h0000, 16'hFFFE);
		send_item(OP_QUERY, 6'd1, 16'h0000, 16'hFFFF);
		send_item(OP_STORE, 6'd3, 16'd1, 16'd1);
		send_item(OP_QUERY, 6'd0, 16'h0000, 16'h0000);
		// A count of zero visits nobody.
		wait_drained();
		write_register(REG_BOID_COUNT, 16'd0);
		send_item(OP_QUERY, 6'd2, 16'hFFFF, 16'hFFFF);
		// A range of zero admits nobody.
		wait_drained();
		write_register(REG_BOID_COUNT, 16'd4);
		write_register(REG_PROT_RANGE, 16'd0);
		send_item(OP_QUERY, 6'd3, 16'h0000, 16'h0000);
		send_item(OP_QUERY, 6'd0, 16'hFFFF, 16'hFFFF);

		// Fill the whole table so that any later query reads written entries.
		for (int k = 0; k < MAX_AGENTS; k++) begin
			send_item(OP_STORE, IDX_W'(k), pick_coord(32768), pick_coord(32768));
		end

		run_phase(64, 128, 0, 0, 300, 1);
		run_phase(127, 65535, 85, 0, 300, 0);
		run_phase(1, 0, 0, 85, 300, 0);
		run_phase(33, 1000, 35, 35, 300, 2);
		run_phase(0, 128, 0, 0, 200, 0);
		run_phase(64, 2000, 35, 35, 450, 0);

		wait_drained();
		$display("Ran %0d transactions and checked %0d separation vectors across seven settings,",
		         tracker.items_taken, tracker.vectors_checked);
		$display("including zero and saturated counts, range extremes and a long output hold.");
		if (tracker.error_count == 0 && tracker.pending_count() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	// Timeout guard.
	initial begin : watchdog
		#(64'd60_000_000);
		$display("Timeout with %0d results still outstanding.", tracker.pending_count());
		$display("status: fail");
		$finish;
	end

endmodule
